>>> rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define CIA_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error(msg);

// Clocked assertion that also runs during reset.
`define CIA_ASSERT_NR(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

>>> rtl/core/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg: shared constants and types
// Opcodes, status codes, cell modes and the control struct of the cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cia_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int OP_W           = 3;
  localparam int ST_W           = 2;
  localparam int MODE_W         = 2;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_REM = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_OVER  = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDER = 2'd2;
  localparam logic [ST_W-1:0] ST_DIV0  = 2'd3;

  // what a cell does with the request it holds
  localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MUL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIV  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              is_rem;
    logic              na;
    logic              nb;
    logic [ST_W-1:0]   status;
  } cia_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/cia_if.sv
// ----------------------------------------------------------------------------
// cia_if: request and result channels
// Valid/ready channels carrying the ALU operation and its checked result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cia_req_if #(
  parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic [cia_pkg::OP_W-1:0]     opcode;
  logic signed [DATA_WIDTH-1:0] left_operand;
  logic signed [DATA_WIDTH-1:0] right_operand;

  modport source (output valid, opcode, left_operand, right_operand, input ready);
  modport sink   (input valid, opcode, left_operand, right_operand, output ready);
endinterface

interface cia_rsp_if #(
  parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result_value;
  logic [cia_pkg::ST_W-1:0]     status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/cia_prep.sv
// ----------------------------------------------------------------------------
// cia_prep: operand decode stage
// Settles add, subtract and all special cases; loads magnitudes for the chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cia_prep #(
  parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  cia_req_if.sink               req,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output cia_pkg::cia_ctl_t     dn_ctl,
  output logic [DATA_WIDTH-1:0] dn_hi,
  output logic [DATA_WIDTH-1:0] dn_lo,
  output logic [DATA_WIDTH-1:0] dn_opnd
);

  localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] ALL_ONE = {DATA_WIDTH{1'b1}};
  localparam logic [DATA_WIDTH-1:0] ZERO    = {DATA_WIDTH{1'b0}};

  logic                  valid_r;
  cia_pkg::cia_ctl_t     ctl_r, ctl_nxt;
  logic [DATA_WIDTH-1:0] hi_r, hi_nxt;
  logic [DATA_WIDTH-1:0] lo_r, lo_nxt;
  logic [DATA_WIDTH-1:0] opnd_r, opnd_nxt;

  logic [DATA_WIDTH-1:0] a, b, ma, mb, sum, dif;
  logic                  na, nb;

  assign a   = req.left_operand;
  assign b   = req.right_operand;
  assign na  = a[DATA_WIDTH-1];
  assign nb  = b[DATA_WIDTH-1];
  assign ma  = na ? (ZERO - a) : a;
  assign mb  = nb ? (ZERO - b) : b;
  assign sum = a + b;
  assign dif = a - b;

  always_comb begin
    ctl_nxt.mode   = cia_pkg::MODE_PASS;
    ctl_nxt.is_rem = (req.opcode == cia_pkg::OP_REM);
    ctl_nxt.na     = na;
    ctl_nxt.nb     = nb;
    ctl_nxt.status = cia_pkg::ST_OK;
    hi_nxt         = ZERO;
    lo_nxt         = ZERO;   // early result value for pass-through requests
    opnd_nxt       = ZERO;
    case (req.opcode)
      cia_pkg::OP_ADD: begin
        if (!na && !nb && sum[DATA_WIDTH-1]) begin
          ctl_nxt.status = cia_pkg::ST_OVER;
        end else if (na && nb && !sum[DATA_WIDTH-1]) begin
          ctl_nxt.status = cia_pkg::ST_UNDER;
        end else begin
          lo_nxt = sum;
        end
      end
      cia_pkg::OP_SUB: begin
        if (!na && nb && dif[DATA_WIDTH-1]) begin
          ctl_nxt.status = cia_pkg::ST_OVER;
        end else if (na && !nb && (b != ZERO) && !dif[DATA_WIDTH-1]) begin
          ctl_nxt.status = cia_pkg::ST_UNDER;
        end else begin
          lo_nxt = dif;
        end
      end
      cia_pkg::OP_MUL: begin
        if ((a != ZERO) && (b != ZERO)) begin
          ctl_nxt.mode = cia_pkg::MODE_MUL;
          lo_nxt       = mb;
          opnd_nxt     = ma;
        end
      end
      cia_pkg::OP_DIV, cia_pkg::OP_REM: begin
        if (b == ZERO) begin
          ctl_nxt.status = cia_pkg::ST_DIV0;
        end else if (a == ZERO) begin
          ctl_nxt.status = cia_pkg::ST_OK;
        end else if ((a == MIN_VAL) && (b == ALL_ONE)) begin
          ctl_nxt.status = cia_pkg::ST_OVER;
        end else begin
          ctl_nxt.mode = cia_pkg::MODE_DIV;
          lo_nxt       = ma;
          opnd_nxt     = mb;
        end
      end
      default: begin
        ctl_nxt.status = cia_pkg::ST_OK;
      end
    endcase
  end

  assign req.ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (req.ready) begin
      valid_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      ctl_r  <= ctl_nxt;
      hi_r   <= hi_nxt;
      lo_r   <= lo_nxt;
      opnd_r <= opnd_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_ctl   = ctl_r;
  assign dn_hi    = hi_r;
  assign dn_lo    = lo_r;
  assign dn_opnd  = opnd_r;

endmodule

`default_nettype wire

>>> rtl/core/cia_cell.sv
// ----------------------------------------------------------------------------
// cia_cell: one step of the multiply / divide chain
// Shift-add multiply step, restoring divide step or pass-through, registered, with handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cia_cell #(
  parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  cia_pkg::cia_ctl_t     up_ctl,
  input  logic [DATA_WIDTH-1:0] up_hi,
  input  logic [DATA_WIDTH-1:0] up_lo,
  input  logic [DATA_WIDTH-1:0] up_opnd,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output cia_pkg::cia_ctl_t     dn_ctl,
  output logic [DATA_WIDTH-1:0] dn_hi,
  output logic [DATA_WIDTH-1:0] dn_lo,
  output logic [DATA_WIDTH-1:0] dn_opnd
);

  logic                  valid_r;
  cia_pkg::cia_ctl_t     ctl_r;
  logic [DATA_WIDTH-1:0] hi_r, hi_nxt;
  logic [DATA_WIDTH-1:0] lo_r, lo_nxt;
  logic [DATA_WIDTH-1:0] opnd_r;

  logic [DATA_WIDTH:0]   msum;   // multiply: high half plus addend
  logic [DATA_WIDTH:0]   trial;  // divide: shifted partial remainder
  logic [DATA_WIDTH:0]   tdif;
  logic                  ge;

  assign msum  = {1'b0, up_hi} + (up_lo[0] ? {1'b0, up_opnd} : {(DATA_WIDTH+1){1'b0}});
  assign trial = {up_hi, up_lo[DATA_WIDTH-1]};
  assign tdif  = trial - {1'b0, up_opnd};
  assign ge    = (trial >= {1'b0, up_opnd});

  always_comb begin
    case (up_ctl.mode)
      cia_pkg::MODE_MUL: begin
        hi_nxt = msum[DATA_WIDTH:1];
        lo_nxt = {msum[0], up_lo[DATA_WIDTH-1:1]};
      end
      cia_pkg::MODE_DIV: begin
        // remainder stays below the divisor, so it fits the low bits
        hi_nxt = ge ? tdif[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
        lo_nxt = {up_lo[DATA_WIDTH-2:0], ge};
      end
      default: begin
        hi_nxt = up_hi;
        lo_nxt = up_lo;
      end
    endcase
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      ctl_r  <= up_ctl;
      hi_r   <= hi_nxt;
      lo_r   <= lo_nxt;
      opnd_r <= up_opnd;
    end
  end

  assign dn_valid = valid_r;
  assign dn_ctl   = ctl_r;
  assign dn_hi    = hi_r;
  assign dn_lo    = lo_r;
  assign dn_opnd  = opnd_r;

endmodule

`default_nettype wire

>>> rtl/core/cia_fin.sv
// ----------------------------------------------------------------------------
// cia_fin: result stage
// Range check of the product, sign fix-up, and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cia_fin #(
  parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  cia_pkg::cia_ctl_t     up_ctl,
  input  logic [DATA_WIDTH-1:0] up_hi,
  input  logic [DATA_WIDTH-1:0] up_lo,
  cia_rsp_if.source             rsp
);

  localparam logic [DATA_WIDTH-1:0]   ZERO    = {DATA_WIDTH{1'b0}};
  localparam logic [DATA_WIDTH-1:0]   MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [2*DATA_WIDTH-1:0] LIM_NEG = {ZERO, MIN_VAL};
  localparam logic [2*DATA_WIDTH-1:0] LIM_POS = {ZERO, MIN_VAL - 1'b1};

  logic                     valid_r;
  logic [DATA_WIDTH-1:0]    result_r, result_nxt;
  logic [cia_pkg::ST_W-1:0] status_r, status_nxt;

  logic [2*DATA_WIDTH-1:0]  prod;
  logic                     neg;

  assign prod = {up_hi, up_lo};
  assign neg  = up_ctl.na ^ up_ctl.nb;

  always_comb begin
    result_nxt = ZERO;
    status_nxt = cia_pkg::ST_OK;
    case (up_ctl.mode)
      cia_pkg::MODE_PASS: begin
        result_nxt = up_lo;
        status_nxt = up_ctl.status;
      end
      cia_pkg::MODE_MUL: begin
        if (prod > (neg ? LIM_NEG : LIM_POS)) begin
          status_nxt = neg ? cia_pkg::ST_UNDER : cia_pkg::ST_OVER;
        end else begin
          result_nxt = neg ? (ZERO - up_lo) : up_lo;
        end
      end
      cia_pkg::MODE_DIV: begin
        // quotient in lo, remainder in hi; remainder follows the dividend sign
        if (up_ctl.is_rem) begin
          result_nxt = up_ctl.na ? (ZERO - up_hi) : up_hi;
        end else begin
          result_nxt = neg ? (ZERO - up_lo) : up_lo;
        end
      end
      default: begin
        result_nxt = ZERO;
      end
    endcase
  end

  assign up_ready = !valid_r || rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      result_r <= result_nxt;
      status_r <= status_nxt;
    end
  end

  assign rsp.valid        = valid_r;
  assign rsp.result_value = result_r;
  assign rsp.status       = status_r;

endmodule

`default_nettype wire

>>> rtl/core/checked_int16_alu.sv
// ----------------------------------------------------------------------------
// checked_int16_alu: signed ALU with overflow / divide-by-zero status
// Registered stages: decode, one chain cell per operand bit, output.
// Throughput one request per cycle while results are taken; a result-channel stall backs up the chain.
// Synchronous active-low reset clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module checked_int16_alu #(
  parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cia_req_if.sink   in_req,
  cia_rsp_if.source out_rsp
);

  // index 0 is the decode stage output, index k the output of cell k-1
  logic                  c_valid [0:DATA_WIDTH];
  logic                  c_ready [0:DATA_WIDTH];
  cia_pkg::cia_ctl_t     c_ctl   [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] c_hi    [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] c_lo    [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] c_opnd  [0:DATA_WIDTH];

  cia_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (in_req),
    .dn_valid (c_valid[0]),
    .dn_ready (c_ready[0]),
    .dn_ctl   (c_ctl[0]),
    .dn_hi    (c_hi[0]),
    .dn_lo    (c_lo[0]),
    .dn_opnd  (c_opnd[0])
  );

  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_cell
    cia_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (c_valid[k]),
      .up_ready (c_ready[k]),
      .up_ctl   (c_ctl[k]),
      .up_hi    (c_hi[k]),
      .up_lo    (c_lo[k]),
      .up_opnd  (c_opnd[k]),
      .dn_valid (c_valid[k+1]),
      .dn_ready (c_ready[k+1]),
      .dn_ctl   (c_ctl[k+1]),
      .dn_hi    (c_hi[k+1]),
      .dn_lo    (c_lo[k+1]),
      .dn_opnd  (c_opnd[k+1])
    );
  end

  cia_fin #(.DATA_WIDTH(DATA_WIDTH)) u_fin (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (c_valid[DATA_WIDTH]),
    .up_ready (c_ready[DATA_WIDTH]),
    .up_ctl   (c_ctl[DATA_WIDTH]),
    .up_hi    (c_hi[DATA_WIDTH]),
    .up_lo    (c_lo[DATA_WIDTH]),
    .rsp      (out_rsp)
  );

endmodule

`default_nettype wire

>>> rtl/core/cia_checker.sv
// ----------------------------------------------------------------------------
// cia_checker: port-level assertions for checked_int16_alu
// Tracks requests in flight and checks result and handshake behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cia_checker #(
  parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [DATA_WIDTH-1:0]    out_result_value,
  input logic [cia_pkg::ST_W-1:0] out_status
);

  localparam int STAGES = DATA_WIDTH + 2;
  localparam int CNT_W  = $clog2(STAGES + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign cnt_nxt = cnt_r + CNT_W'(in_valid && in_ready) - CNT_W'(out_valid && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `CIA_ASSERT(a_err_zero, clk, rst_n, out_valid && (out_status != cia_pkg::ST_OK) |-> out_result_value == '0, "nonzero result with error status")
  `CIA_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_result_value) && $stable(out_status), "stalled result changed")
  `CIA_ASSERT(a_no_orphan, clk, rst_n, out_valid |-> cnt_r != '0, "result without a request in flight")
  `CIA_ASSERT(a_empty_ready, clk, rst_n, (cnt_r == '0) |-> in_ready, "empty pipeline refuses a request")
  `CIA_ASSERT_NR(a_rst_clear, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind checked_int16_alu cia_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cia_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_req.valid),
  .in_ready         (in_req.ready),
  .out_valid        (out_rsp.valid),
  .out_ready        (out_rsp.ready),
  .out_result_value (out_rsp.result_value),
  .out_status       (out_rsp.status)
);

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for checked_int16_alu
// Drives opcode/operand requests through the valid/ready request channel,
// predicts value and status for each accepted request and compares every
// result in order. Both channels idle at random, and one phase holds the
// result channel off long enough to fill the pipeline.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int DW = cia_pkg::DATA_WIDTH_DEF;
  localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam int LATENCY = DW + 2;

  // opcodes with no operation behind them
  localparam logic [cia_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [cia_pkg::OP_W-1:0] OP_SPARE_MID   = 3'd6;
  localparam logic [cia_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [cia_pkg::OP_W-1:0] op;
    logic signed [DW-1:0]     lhs;
    logic signed [DW-1:0]     rhs;
    logic signed [DW-1:0]     value;
    logic [cia_pkg::ST_W-1:0] status;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst_n;

  cia_req_if #(.DATA_WIDTH(DW)) req_if ();
  cia_rsp_if #(.DATA_WIDTH(DW)) rsp_if ();

  checked_int16_alu #(.DATA_WIDTH(DW)) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  alu_result_t pending_results[$];
  int          mismatch_count = 0;
  bit          idling_on = 1'b1;
  int          ready_hold_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

  // Expected value and status of one request, from exact integer arithmetic.
  function automatic alu_result_t predict_alu(input logic [cia_pkg::OP_W-1:0] op,
                                              input logic signed [DW-1:0] lhs,
                                              input logic signed [DW-1:0] rhs);
    alu_result_t r;
    longint      exact;
    bit          range_checked;
    r.op = op;
    r.lhs = lhs;
    r.rhs = rhs;
    r.value = '0;
    r.status = cia_pkg::ST_OK;
    exact = 0;
    range_checked = 1'b0;
    case (op)
      cia_pkg::OP_ADD: begin
        exact = longint'(lhs) + longint'(rhs);
        range_checked = 1'b1;
      end
      cia_pkg::OP_SUB: begin
        exact = longint'(lhs) - longint'(rhs);
        range_checked = 1'b1;
      end
      cia_pkg::OP_MUL: begin
        exact = longint'(lhs) * longint'(rhs);
        range_checked = 1'b1;
      end
      cia_pkg::OP_DIV, cia_pkg::OP_REM: begin
        // zero divisor wins over every other condition
        if (rhs == 0) begin
          r.status = cia_pkg::ST_DIV0;
        end else if (lhs == VAL_MIN && rhs == -1) begin
          r.status = cia_pkg::ST_OVER;
        end else if (op == cia_pkg::OP_DIV) begin
          r.value = lhs / rhs;
        end else begin
          r.value = lhs % rhs;
        end
      end
      default: ;
    endcase
    if (range_checked) begin
      if (exact > longint'(VAL_MAX)) begin
        r.status = cia_pkg::ST_OVER;
      end else if (exact < longint'(VAL_MIN)) begin
        r.status = cia_pkg::ST_UNDER;
      end else begin
        r.value = exact[DW-1:0];
      end
    end
    return r;
  endfunction

  function automatic logic signed [DW-1:0] random_operand();
    logic signed [DW-1:0] v;
    case ($urandom_range(9))
      6: begin
        case ($urandom_range(5))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = '0;
          3: v = 1;
          4: v = -1;
          default: v = VAL_MIN + 1;
        endcase
      end
      // small magnitudes keep sums, differences and quotients in range
      7, 8: v = $urandom_range(600) - 300;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic logic [cia_pkg::OP_W-1:0] random_opcode();
    logic [cia_pkg::OP_W-1:0] op;
    if ($urandom_range(15) == 0) begin
      op = $urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST);
    end else begin
      op = $urandom_range(cia_pkg::OP_REM, cia_pkg::OP_ADD);
    end
    return op;
  endfunction

  // Leaves valid high on return; the next call lowers it only on an idle.
  task automatic send_request(input logic [cia_pkg::OP_W-1:0] op,
                              input logic signed [DW-1:0] lhs,
                              input logic signed [DW-1:0] rhs);
    while (idling_on && $urandom_range(99) < 9) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.opcode        <= op;
    req_if.left_operand  <= lhs;
    req_if.right_operand <= rhs;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_request(cia_pkg::OP_ADD, VAL_MAX, 1);
    send_request(cia_pkg::OP_ADD, VAL_MIN, -1);
    send_request(cia_pkg::OP_ADD, VAL_MAX, VAL_MIN);
    send_request(cia_pkg::OP_ADD, VAL_MIN, VAL_MIN);
    send_request(cia_pkg::OP_SUB, 0, VAL_MIN);
    send_request(cia_pkg::OP_SUB, VAL_MIN, 1);
    send_request(cia_pkg::OP_SUB, -1, VAL_MAX);
    send_request(cia_pkg::OP_SUB, VAL_MIN, 0);
    send_request(cia_pkg::OP_MUL, VAL_MIN, -1);
    send_request(cia_pkg::OP_MUL, VAL_MIN, 1);
    send_request(cia_pkg::OP_MUL, 0, VAL_MIN);
    send_request(cia_pkg::OP_MUL, 256, 128);
    send_request(cia_pkg::OP_MUL, -256, 128);
    send_request(cia_pkg::OP_MUL, 256, -129);
    send_request(cia_pkg::OP_DIV, VAL_MIN, -1);
    send_request(cia_pkg::OP_REM, VAL_MIN, -1);
    send_request(cia_pkg::OP_DIV, 0, 0);
    send_request(cia_pkg::OP_REM, VAL_MAX, 0);
    send_request(cia_pkg::OP_DIV, 0, -5);
    send_request(cia_pkg::OP_DIV, -7, 2);
    send_request(cia_pkg::OP_REM, -7, 2);
    send_request(cia_pkg::OP_REM, 7, -2);
    send_request(OP_SPARE_FIRST, VAL_MAX, VAL_MAX);
    send_request(OP_SPARE_MID, -1, VAL_MIN);
    send_request(OP_SPARE_LAST, VAL_MIN, -1);
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_request(random_opcode(), random_operand(), random_operand());
  endtask

  task automatic test_back_to_back(input int count);
    idling_on = 1'b0;
    repeat (count) send_request(random_opcode(), random_operand(), random_operand());
    idling_on = 1'b1;
  endtask

  // Result channel stalls long enough for the pipeline to fill and push back.
  task automatic test_result_backpressure(input int count);
    ready_hold_cycles = 300;
    repeat (count) send_request(random_opcode(), random_operand(), random_operand());
  endtask

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (ready_hold_cycles > 0) begin
        ready_hold_cycles--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= !(idling_on && $urandom_range(99) < 9);
      end
    end
  end

  always @(posedge clk) begin : result_check
    alu_result_t expected;
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        pending_results.push_back(predict_alu(req_if.opcode, req_if.left_operand,
                                              req_if.right_operand));
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got value %0d status %0d",
                   $time, rsp_if.result_value, rsp_if.status);
          mismatch_count++;
        end else begin
          expected = pending_results.pop_front();
          if (rsp_if.result_value !== expected.value) begin
            $display("%0t: value mismatch op %0d lhs %0d rhs %0d: expected %0d got %0d",
                     $time, expected.op, expected.lhs, expected.rhs, expected.value,
                     rsp_if.result_value);
            mismatch_count++;
          end
          if (rsp_if.status !== expected.status) begin
            $display("%0t: status mismatch op %0d lhs %0d rhs %0d: expected %0d got %0d",
                     $time, expected.op, expected.lhs, expected.rhs, expected.status,
                     rsp_if.status);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    int drain_cycles;
    rst_n                <= 1'b0;
    req_if.valid         <= 1'b0;
    req_if.opcode        <= cia_pkg::OP_ADD;
    req_if.left_operand  <= '0;
    req_if.right_operand <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_mix(1000);
    test_back_to_back(400);
    test_result_backpressure(150);
    req_if.valid <= 1'b0;

    drain_cycles = 0;
    while (pending_results.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived, expected value %0d got none",
               $time, pending_results.size(), pending_results[0].value);
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
